// ===== rtl/spn_pkg.sv =====
// types, constants and round functions shared by the spn cipher block
package spn_pkg;

  localparam int BLOCK_W    = 16;
  localparam int KEY_W      = 32;
  localparam int TABLE_W    = 64;
  localparam int NIB_W      = 4;
  localparam int NUM_NIB    = BLOCK_W / NIB_W;
  localparam int NUM_STAGES = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int ROUND_W    = 3;

  localparam logic [ROUND_W-1:0] ROUND_FIRST = 3'd0;
  localparam logic [ROUND_W-1:0] ROUND_LAST  = 3'd4;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SBOX     = 2'd0,
    CFG_INV_SBOX = 2'd1,
    CFG_PERM     = 2'd2
  } cfg_reg_t;

  typedef logic [NIB_W-1:0]   nib_t;
  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [TABLE_W-1:0] table_t;

  typedef struct packed {
    logic found;
    nib_t src;
  } inv_entry_t;

  typedef inv_entry_t [BLOCK_W-1:0] inv_map_t;

  typedef struct packed {
    table_t   sbox;
    table_t   inv_sbox;
    table_t   perm;
    inv_map_t inv_map;
  } tables_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    block_t           w;
  } item_t;

  typedef struct packed {
    logic [ROUND_W-1:0] enc_round;
    logic [ROUND_W-1:0] dec_round;
    logic               enc_perm;
    logic               dec_unperm;
    logic               last;
  } round_ctrl_t;

  function automatic round_ctrl_t stage_ctrl(int s);
    round_ctrl_t c;
    case (s)
      0:       c = '{enc_round: 3'd0, dec_round: 3'd4, enc_perm: 1'b1, dec_unperm: 1'b0,
                     last: 1'b0};
      1:       c = '{enc_round: 3'd1, dec_round: 3'd3, enc_perm: 1'b1, dec_unperm: 1'b1,
                     last: 1'b0};
      2:       c = '{enc_round: 3'd2, dec_round: 3'd2, enc_perm: 1'b1, dec_unperm: 1'b1,
                     last: 1'b0};
      default: c = '{enc_round: 3'd3, dec_round: 3'd1, enc_perm: 1'b0, dec_unperm: 1'b1,
                     last: 1'b1};
    endcase
    return c;
  endfunction

  function automatic block_t round_key(logic [KEY_W-1:0] key, logic [ROUND_W-1:0] r);
    logic [KEY_W-1:0] sh;
    sh = key >> (16 - 4 * int'(r));
    return sh[BLOCK_W-1:0];
  endfunction

  function automatic block_t substitute(table_t tbl, block_t x);
    block_t y;
    nib_t   nib;
    y = '0;
    for (int n = 0; n < NUM_NIB; n++) begin
      nib = x[BLOCK_W-1-NIB_W*n -: NIB_W];
      y[BLOCK_W-1-NIB_W*n -: NIB_W] = tbl[TABLE_W-1-NIB_W*int'(nib) -: NIB_W];
    end
    return y;
  endfunction

  function automatic block_t permute(table_t perm, block_t x);
    block_t y;
    nib_t   src;
    y = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      src = perm[TABLE_W-1-NIB_W*i -: NIB_W];
      y[BLOCK_W-1-i] = x[BLOCK_W-1-int'(src)];
    end
    return y;
  endfunction

  function automatic block_t unpermute(inv_map_t inv, block_t x);
    block_t y;
    y = '0;
    for (int k = 0; k < BLOCK_W; k++) begin
      y[BLOCK_W-1-k] = inv[k].found & x[BLOCK_W-1-int'(inv[k].src)];
    end
    return y;
  endfunction

  // lowest field index naming each position wins
  function automatic inv_map_t derive_inverse(table_t perm);
    inv_map_t inv;
    for (int k = 0; k < BLOCK_W; k++) begin
      inv[k] = '{found: 1'b0, src: '0};
      for (int i = BLOCK_W - 1; i >= 0; i--) begin
        if (perm[TABLE_W-1-NIB_W*i -: NIB_W] == NIB_W'(k)) begin
          inv[k] = '{found: 1'b1, src: NIB_W'(i)};
        end
      end
    end
    return inv;
  endfunction

endpackage

// ===== rtl/spn_cfg.sv =====
// configuration registers and derived inverse permutation
module spn_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spn_pkg::TABLE_W-1:0]      cfg_data,
  output spn_pkg::tables_t                 tables
);
  import spn_pkg::*;

  table_t   sbox;
  table_t   inv_sbox;
  table_t   perm;
  inv_map_t inv_map;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sbox     <= '0;
      inv_sbox <= '0;
      perm     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SBOX:     sbox     <= cfg_data;
        CFG_INV_SBOX: inv_sbox <= cfg_data;
        CFG_PERM:     perm     <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_map <= derive_inverse('0);
    end else begin
      inv_map <= derive_inverse(perm);
    end
  end

  assign tables = '{sbox: sbox, inv_sbox: inv_sbox, perm: perm, inv_map: inv_map};

endmodule

// ===== rtl/spn_round.sv =====
// one registered cipher round stage with valid/ready flow control
module spn_round (
  input  logic                 clk,
  input  logic                 rst,
  input  spn_pkg::round_ctrl_t ctrl,
  input  spn_pkg::tables_t     tables,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spn_pkg::item_t       in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spn_pkg::item_t       out_item
);
  import spn_pkg::*;

  logic   valid;
  item_t  item;
  item_t  item_next;
  block_t kin;
  block_t kout;
  block_t enc_w;
  block_t dec_w;

  always_comb begin
    kin  = (in_item.kind == KIND_DEC) ? round_key(in_item.key, ctrl.dec_round)
                                      : round_key(in_item.key, ctrl.enc_round);
    kout = '0;
    if (ctrl.last) begin
      kout = (in_item.kind == KIND_DEC) ? round_key(in_item.key, ROUND_FIRST)
                                        : round_key(in_item.key, ROUND_LAST);
    end

    enc_w = substitute(tables.sbox, in_item.w ^ kin);
    if (ctrl.enc_perm) begin
      enc_w = permute(tables.perm, enc_w);
    end

    dec_w = in_item.w ^ kin;
    if (ctrl.dec_unperm) begin
      dec_w = unpermute(tables.inv_map, dec_w);
    end
    dec_w = substitute(tables.inv_sbox, dec_w);

    item_next      = in_item;
    item_next.w    = ((in_item.kind == KIND_DEC) ? dec_w : enc_w) ^ kout;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

// ===== rtl/spn_block_cipher_16bit_unit.sv =====
// top level of the four-round 16-bit spn block cipher
// each round stage registers its result in turn, one round per stage
// throughput: one item per cycle while the output is not stalled; a stage loads when empty or when its successor moves
// a stalled output holds each full stage with no empty stage below it; no item is dropped or repeated
// reset clears all stage valid bits and loads zero into the three tables
module spn_block_cipher_16bit_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spn_pkg::TABLE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [spn_pkg::KEY_W-1:0]     cipher_key,
  input  logic [spn_pkg::BLOCK_W-1:0]   data_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spn_pkg::BLOCK_W-1:0]   result_block
);
  import spn_pkg::*;

  tables_t tables;
  logic    stage_valid [NUM_STAGES+1];
  logic    stage_ready [NUM_STAGES+1];
  item_t   stage_item  [NUM_STAGES+1];

  spn_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tables    (tables)
  );

  assign stage_valid[0] = in_valid;
  assign in_ready       = stage_ready[0];
  assign stage_item[0]  = '{kind: kind, key: cipher_key, w: data_block};

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_round
    spn_round u_round (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (stage_ctrl(s)),
      .tables    (tables),
      .in_valid  (stage_valid[s]),
      .in_ready  (stage_ready[s]),
      .in_item   (stage_item[s]),
      .out_valid (stage_valid[s+1]),
      .out_ready (stage_ready[s+1]),
      .out_item  (stage_item[s+1])
    );
  end

  assign out_valid                = stage_valid[NUM_STAGES];
  assign stage_ready[NUM_STAGES]  = out_ready;
  assign result_block             = stage_item[NUM_STAGES].w;

endmodule

// ===== rtl/spn_checker.sv =====
// port-level checks for the spn cipher block and their binding
module spn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [spn_pkg::BLOCK_W-1:0]   result_block
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_block))
    else $error("result changed while stalled");

  // a free output means the whole pipe can move
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input blocked with free output");

  // checks that out_valid is up once an accepted item has passed every round stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##4 out_valid)
    else $error("no result after pipeline latency");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spn_block_cipher_16bit_unit spn_checker u_spn_checker (.*);
